// ----- hdl/contiguous_frame_allocator_top_macros.svh -----
// Assertion helpers; the enclosing module supplies clk and rst_n.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define CFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfa assertion failed");

// Next-cycle implication.
`define CFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfa assertion failed");

`endif

// ----- hdl/cfa_pkg.sv -----
package cfa_pkg;

    localparam int MAX_FRAMES_DEF = 4096;

    localparam int FRAME_W  = 20;
    localparam int LEN_W    = 13;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int FSTATE_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LEN_W-1:0] COUNT_RESET = LEN_W'(4096);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK    = 2'd2;

    // per-frame state codes
    localparam logic [FSTATE_W-1:0] FS_FREE      = 2'd0;
    localparam logic [FSTATE_W-1:0] FS_ALLOCATED = 2'd1;
    localparam logic [FSTATE_W-1:0] FS_BLOCKED   = 2'd2;
    localparam logic [FSTATE_W-1:0] FS_HEAD      = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_OUTSIDE  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_HEAD = 2'd3;

    // register indexes (paddr bit 2)
    localparam logic REG_BASE_IDX  = 1'b0;
    localparam logic REG_COUNT_IDX = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FRAME_W-1:0]  frame_number;
        logic [LEN_W-1:0]    frame_run_length;
        logic                blocked;
    } cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  first_frame;
        logic [STATUS_W-1:0] status;
    } res_t;

    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [LEN_W-1:0]   count;
    } pool_cfg_t;

endpackage

// ----- hdl/cfa_ram.sv -----
module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cfa_engine.sv -----
`include "contiguous_frame_allocator_top_macros.svh"

module cfa_engine import cfa_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  pool_cfg_t cfg,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_t      cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_t      res
);

    localparam int FIDX_W = $clog2(MAX_FRAMES);
    localparam int SIZE_W = $clog2(MAX_FRAMES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_REL_RD,
        S_REL_CHK,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   idx_reg, idx_next;
    logic [SIZE_W-1:0]   chk_reg, chk_next;
    logic                pend_reg, pend_next;
    logic [SIZE_W-1:0]   run_reg, run_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    logic                first_reg, first_next;
    logic [FSTATE_W-1:0] head_reg, head_next;
    logic [FSTATE_W-1:0] rest_reg, rest_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FRAME_W-1:0]  ff_reg, ff_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic [SIZE_W-1:0]   size;
    logic [FRAME_W:0]    diff;
    logic                in_pool;
    logic                range_fits;
    logic [SIZE_W-1:0]   off;
    logic [SIZE_W-1:0]   start_n;

    logic                we;
    logic [FIDX_W-1:0]   waddr;
    logic [FSTATE_W-1:0] wdata;
    logic [FIDX_W-1:0]   raddr;
    logic [FSTATE_W-1:0] rdata;

    cfa_ram #(
        .WIDTH (FSTATE_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // pool holds min(count, MAX_FRAMES) frames
    always_comb
    begin
        if (32'(cfg.count) > 32'(MAX_FRAMES))
        begin
            size = SIZE_W'(MAX_FRAMES);
        end
        else
        begin
            size = SIZE_W'(cfg.count);
        end
    end

    assign diff       = {1'b0, cmd.frame_number} - {1'b0, cfg.base};
    assign in_pool    = !diff[FRAME_W] && (32'(diff[FRAME_W-1:0]) < 32'(size));
    assign range_fits = (32'(diff[FRAME_W-1:0]) + 32'(cmd.frame_run_length)) <= 32'(size);
    assign off        = SIZE_W'(diff[FRAME_W-1:0]);
    assign start_n    = (run_reg == '0) ? chk_reg : SIZE_W'(idx_reg - SIZE_W'(32'(run_reg) + 1));

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        first_next     = first_reg;
        head_next      = head_reg;
        rest_next      = rest_reg;
        status_next    = status_reg;
        ff_next        = ff_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        we    = 1'b0;
        waddr = idx_reg[FIDX_W-1:0];
        wdata = FS_FREE;
        raddr = idx_reg[FIDX_W-1:0];

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                wdata    = FS_FREE;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SIZE_W'(MAX_FRAMES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ff_next     = '0;
                    len_next    = cmd.frame_run_length;
                    left_next   = cmd.frame_run_length;
                    first_next  = 1'b1;
                    status_next = STS_OK;
                    state_next  = S_FINISH;
                    unique case (cmd.action)
                        ACT_ALLOC:
                        begin
                            if (cmd.frame_run_length == '0)
                            begin
                                status_next = STS_NO_SPACE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                pend_next  = 1'b0;
                                run_next   = '0;
                                head_next  = FS_HEAD;
                                rest_next  = FS_ALLOCATED;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_RELEASE:
                        begin
                            if (!in_pool)
                            begin
                                status_next = STS_OUTSIDE;
                            end
                            else
                            begin
                                idx_next   = off;
                                state_next = S_REL_RD;
                            end
                        end
                        ACT_MARK:
                        begin
                            if (cmd.frame_run_length == '0)
                            begin
                                status_next = STS_NO_SPACE;
                            end
                            else if (!in_pool || !range_fits)
                            begin
                                status_next = STS_OUTSIDE;
                            end
                            else
                            begin
                                idx_next   = off;
                                head_next  = cmd.blocked ? FS_BLOCKED : FS_HEAD;
                                rest_next  = cmd.blocked ? FS_BLOCKED : FS_ALLOCATED;
                                state_next = S_WRITE;
                            end
                        end
                        default:
                        begin
                            status_next = STS_NO_SPACE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, data checked in the following cycle
                if (idx_reg < size)
                begin
                    idx_next  = idx_reg + 1'b1;
                    chk_next  = idx_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (rdata == FS_FREE)
                    begin
                        run_next = run_reg + 1'b1;
                        if ((32'(run_reg) + 1) >= 32'(len_reg))
                        begin
                            idx_next   = start_n;
                            left_next  = len_reg;
                            first_next = 1'b1;
                            ff_next    = FRAME_W'(32'(cfg.base) + 32'(start_n));
                            pend_next  = 1'b0;
                            state_next = S_WRITE;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (idx_reg >= size)
                begin
                    status_next = STS_NO_SPACE;
                    state_next  = S_FINISH;
                end
            end

            S_WRITE:
            begin
                we         = 1'b1;
                wdata      = first_reg ? head_reg : rest_reg;
                idx_next   = idx_reg + 1'b1;
                left_next  = left_reg - 1'b1;
                first_next = 1'b0;
                if (left_reg == LEN_W'(1))
                begin
                    status_next = STS_OK;
                    state_next  = S_FINISH;
                end
            end

            S_REL_RD:
            begin
                // release runs to the pool end at most
                if (idx_reg >= size)
                begin
                    status_next = STS_OK;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_REL_CHK;
                end
            end

            S_REL_CHK:
            begin
                if (first_reg && rdata != FS_HEAD)
                begin
                    status_next = STS_NOT_HEAD;
                    state_next  = S_FINISH;
                end
                else if (first_reg || rdata == FS_ALLOCATED)
                begin
                    we         = 1'b1;
                    wdata      = FS_FREE;
                    idx_next   = idx_reg + 1'b1;
                    first_next = 1'b0;
                    state_next = S_REL_RD;
                end
                else
                begin
                    status_next = STS_OK;
                    state_next  = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next       = 1'b1;
                    res_next.first_frame = ff_reg;
                    res_next.status      = status_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            chk_reg       <= '0;
            pend_reg      <= 1'b0;
            run_reg       <= '0;
            len_reg       <= '0;
            left_reg      <= '0;
            first_reg     <= 1'b0;
            head_reg      <= FS_FREE;
            rest_reg      <= FS_FREE;
            status_reg    <= STS_OK;
            ff_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
            len_reg       <= len_next;
            left_reg      <= left_next;
            first_reg     <= first_next;
            head_reg      <= head_next;
            rest_reg      <= rest_next;
            status_reg    <= status_next;
            ff_reg        <= ff_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    `CFA_ASSERT_IMPL(a_wr_in_pool, we && (state_reg != S_CLEAR), 32'(waddr) < 32'(size))
    `CFA_ASSERT_IMPL(a_write_left, state_reg == S_WRITE, left_reg != '0)
    `CFA_ASSERT_IMPL(a_scan_run, state_reg == S_SCAN, 32'(run_reg) < 32'(len_reg))
    `CFA_ASSERT_IMPL(a_res_from_finish, $rose(res_valid_reg), $past(state_reg == S_FINISH))
    `CFA_ASSERT_NEXT(a_cmd_leaves_idle, (state_reg == S_IDLE) && cmd_valid, state_reg != S_IDLE)

endmodule

// ----- hdl/contiguous_frame_allocator_top.sv -----
// Contiguous frame allocator: keeps a 2-bit state for each frame of one pool in a
// MAX_FRAMES-entry RAM and serves one command at a time. The RAM's single read port
// sets the pace: allocate walks the frame states first-fit one frame per cycle,
// then writes the run; mark writes the run directly; release reads and checks
// each frame before freeing it; rejected commands go straight to the result.
// After reset the whole RAM is swept to free, with cmd_stall high; the APB
// registers can be written during the sweep. Results leave through an output
// register, one transfer per command.
module contiguous_frame_allocator_top import cfa_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output res_t               res
);

    logic [FRAME_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               apb_wr;
    pool_cfg_t          pool_cfg;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_comb
    begin
        base_next  = base_reg;
        count_next = count_reg;
        if (apb_wr)
        begin
            unique case (paddr[2])
                REG_BASE_IDX:  base_next  = pwdata[FRAME_W-1:0];
                REG_COUNT_IDX: count_next = pwdata[LEN_W-1:0];
                default:       base_next  = base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BASE_IDX:  prdata = PDATA_W'(base_reg);
            REG_COUNT_IDX: prdata = PDATA_W'(count_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= COUNT_RESET;
        end
        else
        begin
            base_reg  <= base_next;
            count_reg <= count_next;
        end
    end

    assign pool_cfg.base  = base_reg;
    assign pool_cfg.count = count_reg;

    cfa_engine #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (pool_cfg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
